### hdl/ssb_pkg.sv
package ssb_pkg;

    // Display geometry and field widths.
    localparam int NumDigits = 6;
    localparam int DigitW    = 4;
    localparam int SegW      = 8;
    localparam int TimeW     = 7;
    localparam int CountW    = 8;
    localparam int PosW      = 3;

    // Stream and register port widths.
    localparam int InDataW   = 40;
    localparam int OutDataW  = 16;
    localparam int AddrW     = 3;
    localparam int ApbDataW  = 32;

    // Decimal point position in the segment byte.
    localparam int SegDpBit  = 7;
    localparam logic [PosW-1:0] LastPos = PosW'(NumDigits - 1);

    // Reset values of the blink timing registers.
    localparam logic [TimeW-1:0] BlinkOnReset  = TimeW'(50);
    localparam logic [TimeW-1:0] BlinkOffReset = TimeW'(50);

    // Register select, taken from the word address.
    typedef enum logic [0:0] {
        REG_BLINK_ON  = 1'b0,
        REG_BLINK_OFF = 1'b1
    } reg_sel_t;

    // One refresh request.
    typedef struct packed {
        logic                              alarm_blink;
        logic [NumDigits-1:0]              blink_mask;
        logic [NumDigits-1:0]              point_mask;
        logic [NumDigits-1:0][DigitW-1:0]  digits;
    } item_t;

    // Scan and blink state as seen by the decoder.
    typedef struct packed {
        logic [PosW-1:0]   pos;
        logic              blank;
    } scan_state_t;

    // One result, segments in the lowest bits.
    typedef struct packed {
        logic                 alarm_led;
        logic [NumDigits-1:0] digit_enable;
        logic [SegW-1:0]      segments;
    } result_t;

    // Hex glyphs, bit 0 is segment a, bit 6 is segment g.
    function automatic logic [SegW-2:0] hex_glyph(input logic [DigitW-1:0] value);
        logic [SegW-2:0] glyph;
        case (value)
            4'h0:    glyph = 7'h3F;
            4'h1:    glyph = 7'h06;
            4'h2:    glyph = 7'h5B;
            4'h3:    glyph = 7'h4F;
            4'h4:    glyph = 7'h66;
            4'h5:    glyph = 7'h6D;
            4'h6:    glyph = 7'h7D;
            4'h7:    glyph = 7'h07;
            4'h8:    glyph = 7'h7F;
            4'h9:    glyph = 7'h6F;
            4'hA:    glyph = 7'h77;
            4'hB:    glyph = 7'h7C;
            4'hC:    glyph = 7'h58;
            4'hD:    glyph = 7'h5E;
            4'hE:    glyph = 7'h79;
            4'hF:    glyph = 7'h71;
            default: glyph = 7'h00;
        endcase
        return glyph;
    endfunction

endpackage

### hdl/ssb_timing.sv
module ssb_timing
    import ssb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [TimeW-1:0] blink_on_time,
    input  logic [TimeW-1:0] blink_off_time,
    output scan_state_t      state
);

    logic [PosW-1:0]   pos_reg;
    logic [PosW-1:0]   pos_next;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_next;
    logic              blank_reg;
    logic              blank_next;
    logic [CountW-1:0] count_inc;
    logic [CountW-1:0] period;

    // Blink counter: step, enter the blank phase at the on time, wrap at the period.
    always_comb
    begin
        count_inc  = count_reg + CountW'(1);
        period     = CountW'(blink_on_time) + CountW'(blink_off_time);
        count_next = count_inc;
        blank_next = blank_reg;
        if (count_inc == CountW'(blink_on_time))
        begin
            blank_next = 1'b1;
        end
        else if (count_inc >= period)
        begin
            blank_next = 1'b0;
            count_next = '0;
        end
    end

    // Scan position walks over the digits; an unused position returns to zero.
    always_comb
    begin
        if (pos_reg < LastPos)
        begin
            pos_next = pos_reg + PosW'(1);
        end
        else
        begin
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
            blank_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            blank_reg <= blank_next;
        end
    end

    // The decoder sees the phase after this tick's counter update.
    assign state.pos   = pos_reg;
    assign state.blank = blank_next;

endmodule

### hdl/ssb_decode.sv
module ssb_decode
    import ssb_pkg::*;
(
    input  item_t       item,
    input  scan_state_t state,
    output result_t     result
);

    logic [SegW-1:0]      seg;
    logic [NumDigits-1:0] enable;
    logic                 alarm;

    // Segment pattern, decimal point and blanking for the scanned digit.
    always_comb
    begin
        seg    = '0;
        enable = '0;
        alarm  = 1'b0;
        if (state.pos <= LastPos)
        begin
            seg[SegW-2:0] = hex_glyph(item.digits[state.pos]);
            seg[SegDpBit] = item.point_mask[state.pos];
            if (item.blink_mask[state.pos] && state.blank)
            begin
                seg = '0;
            end
            enable = NumDigits'(1 << (LastPos - state.pos));
            alarm  = item.alarm_blink && state.blank;
        end
    end

    assign result.segments     = seg;
    assign result.digit_enable = enable;
    assign result.alarm_led    = alarm;

endmodule

### hdl/ssb_out_buf.sv
module ssb_out_buf
    import ssb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    load_in;

    // The skid stage takes a request while the output register is stalled.
    assign in_ready = !skid_valid_reg;
    assign load_in  = in_valid && in_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (load_in)
            begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (load_in)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hdl/seven_segment_scan_blink_unit.sv
// Six-digit multiplexed seven-segment driver with blinking.
// Each request on the slave stream is one refresh tick carrying the six hex
// digits, the decimal-point mask, the blink mask and the alarm-blink flag.
// Each tick yields one result on the master stream: the segment byte of the
// scanned digit, its one-hot digit enable and the alarm LED drive.
// Blink on and off times are written over the APB port at byte addresses
// 0 and 4; write them only while no tick is in flight.
// A result is registered from the decode of its accepted request, and a new
// request can be taken every cycle while the receiver keeps up: one tick per
// clock, set by the single decode stage feeding the result register.
// When the receiver stalls, one further request is held in a skid register
// and s_tready then drops until the output drains.
// Reset clears the scan position, the blink counter and the blank phase,
// empties the output stage and loads both blink times with 50.

module seven_segment_scan_blink_unit
    import ssb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Slave stream. s_tdata from bit 0: digit0..digit5 (4 bits each),
    // point_mask (6), blink_mask (6), alarm_blink (1), zero padding (3).
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,
    // Master stream. m_tdata from bit 0: segments (8), digit_enable (6),
    // alarm_led (1), zero padding (1).
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    logic [TimeW-1:0] blink_on_reg;
    logic [TimeW-1:0] blink_off_reg;
    logic             cfg_write;
    reg_sel_t         reg_sel;
    item_t            item;
    scan_state_t      scan_state;
    result_t          result;
    result_t          out_data;
    logic             accept;

    // Configuration registers, selected by the word address.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = reg_sel_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_on_reg  <= BlinkOnReset;
            blink_off_reg <= BlinkOffReset;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_BLINK_ON:  blink_on_reg  <= pwdata[TimeW-1:0];
                REG_BLINK_OFF: blink_off_reg <= pwdata[TimeW-1:0];
                default:       blink_on_reg  <= blink_on_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BLINK_ON:  prdata = ApbDataW'(blink_on_reg);
            REG_BLINK_OFF: prdata = ApbDataW'(blink_off_reg);
            default:       prdata = '0;
        endcase
    end

    // Unpack the request.
    always_comb
    begin
        for (int i = 0; i < NumDigits; i++)
        begin
            item.digits[i] = s_tdata[i*DigitW +: DigitW];
        end
        item.point_mask  = s_tdata[NumDigits*DigitW +: NumDigits];
        item.blink_mask  = s_tdata[NumDigits*DigitW + NumDigits +: NumDigits];
        item.alarm_blink = s_tdata[NumDigits*DigitW + 2*NumDigits];
    end

    assign accept = s_tvalid && s_tready;

    ssb_timing u_timing (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (accept),
        .blink_on_time  (blink_on_reg),
        .blink_off_time (blink_off_reg),
        .state          (scan_state)
    );

    ssb_decode u_decode (
        .item   (item),
        .state  (scan_state),
        .result (result)
    );

    ssb_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {1'b0, out_data};

    // At most one digit driver is on in any result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tdata[SegW +: NumDigits]))
        else $error("digit enable is not one-hot");

    // The scan position never leaves the six digit positions.
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_state.pos <= LastPos)
        else $error("scan position out of range");

    // A request held in the skid stage implies a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !$past(m_tready))
        else $error("skid stage full without a stalled output");

    // An accepted tick below the last position advances the scan position by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && scan_state.pos != LastPos |=>
            scan_state.pos == $past(scan_state.pos) + PosW'(1))
        else $error("scan position did not advance");

endmodule
